>>> rtl/pse_pkg.sv
// shared constants, types and command/status structs of the postfix stack evaluator
`default_nettype none
package pse_pkg;

   localparam int STACK_DEPTH    = 16;
   localparam int VARIABLE_COUNT = 26;
   localparam int DATA_W         = 32;
   localparam int CNT_W          = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W         = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int VAR_W          = 5;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_UNDERFLOW = 3'd1;
   localparam logic [2:0] ST_DIVZERO   = 3'd2;
   localparam logic [2:0] ST_OVERFLOW  = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   // characters
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_MUL   = 8'h2A;
   localparam logic [7:0] CH_DIV   = 8'h2F;
   localparam logic [7:0] CH_MOD   = 8'h25;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // controller to datapath
   typedef struct packed {
      logic       load_item;
      logic       var_write;
      logic       push_var;
      logic       err_write;
      logic [2:0] err_code;
      logic       rd_second;
      logic       cap_rhs;
      logic       cap_lhs;
      logic       alu_exec;
      logic       div_start;
      logic       div_take;
      logic       push_result;
      logic       emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_load;
      logic has_error;
      logic is_letter;
      logic is_space;
      logic stack_full;
      logic under_two;
      logic is_div;
      logic rhs_zero;
      logic div_done;
      logic last;
      logic rsp_free;
   } sts_type;

endpackage
`default_nettype wire

>>> rtl/pse_ram.sv
// generic single write, single registered read port ram
`default_nettype none
module pse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> rtl/pse_divider.sv
// iterative signed 32-bit divider, one quotient bit per cycle
`default_nettype none
module pse_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic                       want_rem,
   input  wire logic [pse_pkg::DATA_W-1:0] dividend,
   input  wire logic [pse_pkg::DATA_W-1:0] divisor,
   output logic                            done,
   output logic      [pse_pkg::DATA_W-1:0] result
);

   localparam int DW = pse_pkg::DATA_W;
   localparam int SW = $clog2(DW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [SW-1:0] step_ff, step_in;
   logic          neg_q_ff, neg_r_ff, rem_sel_ff;
   logic [DW-1:0] mb_ff, rem_ff, rem_in, quo_ff, quo_in;
   logic [DW:0]   shifted, diff;
   logic [DW-1:0] mag_a, mag_b;

   // operand magnitudes
   assign mag_a = dividend[DW-1] ? (DW'(0) - dividend) : dividend;
   assign mag_b = divisor[DW-1] ? (DW'(0) - divisor) : divisor;

   // one restoring step
   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      diff    = shifted - {1'b0, mb_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = mag_a;
      end else if (busy_ff) begin
         step_in = step_ff + SW'(1);
         if (!diff[DW]) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         if (step_ff == SW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         mb_ff      <= mag_b;
         neg_q_ff   <= dividend[DW-1] ^ divisor[DW-1];
         neg_r_ff   <= dividend[DW-1];
         rem_sel_ff <= want_rem;
      end
   end

   // sign correction
   always_comb begin
      if (rem_sel_ff) begin
         result = neg_r_ff ? (DW'(0) - rem_ff) : rem_ff;
      end else begin
         result = neg_q_ff ? (DW'(0) - quo_ff) : quo_ff;
      end
   end

   assign done = done_ff;

endmodule
`default_nettype wire

>>> rtl/pse_datapath.sv
// stack, variable table, alu and result register of the evaluator
`default_nettype none
module pse_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire pse_pkg::cmd_type            cmd,
   output pse_pkg::sts_type                 sts,
   input  wire logic                        req_opcode,
   input  wire logic [7:0]                  req_token_char,
   input  wire logic [4:0]                  req_var_index,
   input  wire logic signed [31:0]          req_var_value,
   input  wire logic                        req_last_token,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [31:0]               rsp_result_value,
   output logic      [2:0]                  rsp_status
);

   localparam int DW = pse_pkg::DATA_W;
   localparam int CW = pse_pkg::CNT_W;
   localparam int AW = pse_pkg::ADDR_W;
   localparam int VC = pse_pkg::VARIABLE_COUNT;

   logic          opcode_ff, last_ff;
   logic [7:0]    char_ff;
   logic [4:0]    idx_ff;
   logic [DW-1:0] val_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [2:0]    err_ff, err_in;
   logic [DW-1:0] rhs_ff, lhs_ff, result_ff, result_in;
   logic [VC-1:0] var_valid_ff;
   logic [DW-1:0] var_data_ff [VC];
   logic [7:0]    letter_off;
   logic [4:0]    letter_idx;
   logic [DW-1:0] var_rd;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [DW-1:0] wr_data, rd_data;
   logic          div_done;
   logic [DW-1:0] div_result;
   logic          rsp_valid_ff;
   logic [DW-1:0] rsp_value_ff;
   logic [2:0]    rsp_status_ff;

   // item register
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         opcode_ff <= req_opcode;
         char_ff   <= req_token_char;
         idx_ff    <= req_var_index;
         val_ff    <= req_var_value;
         last_ff   <= req_last_token;
      end
   end

   // variable table, entries read as zero until written
   assign letter_off = char_ff - pse_pkg::CH_A;
   assign letter_idx = letter_off[4:0];
   assign var_rd     = var_valid_ff[letter_idx] ? var_data_ff[letter_idx] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         var_valid_ff <= '0;
      end else if (cmd.var_write && idx_ff < 5'(VC)) begin
         var_valid_ff[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.var_write && idx_ff < 5'(VC)) begin
         var_data_ff[idx_ff] <= val_ff;
      end
   end

   // value stack
   assign wr_en   = cmd.push_var || cmd.push_result;
   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = cmd.push_var ? var_rd : result_ff;
   assign rd_addr = cmd.rd_second ? AW'(count_ff - CW'(2)) : AW'(count_ff - CW'(1));

   pse_ram #(
      .WIDTH (DW),
      .DEPTH (pse_pkg::STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // stack count and sticky error
   always_comb begin
      count_in = count_ff;
      err_in   = err_ff;
      priority if (cmd.emit) begin
         count_in = '0;
      end else if (cmd.cap_lhs) begin
         count_in = count_ff - CW'(2);
      end else if (wr_en) begin
         count_in = count_ff + CW'(1);
      end
      priority if (cmd.emit) begin
         err_in = pse_pkg::ST_OK;
      end else if (cmd.err_write) begin
         err_in = cmd.err_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         err_ff   <= pse_pkg::ST_OK;
      end else begin
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   // operand capture
   always_ff @(posedge clock) begin
      if (cmd.cap_rhs) begin
         rhs_ff <= rd_data;
      end
      if (cmd.cap_lhs) begin
         lhs_ff <= rd_data;
      end
   end

   // divider result or add, sub, mul; other chars give zero
   always_comb begin
      result_in = result_ff;
      if (cmd.div_take) begin
         result_in = div_result;
      end else if (cmd.alu_exec) begin
         unique case (char_ff)
            pse_pkg::CH_PLUS:  result_in = lhs_ff + rhs_ff;
            pse_pkg::CH_MINUS: result_in = lhs_ff - rhs_ff;
            pse_pkg::CH_MUL:   result_in = lhs_ff * rhs_ff;
            default:           result_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   pse_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .want_rem (char_ff == pse_pkg::CH_MOD),
      .dividend (lhs_ff),
      .divisor  (rhs_ff),
      .done     (div_done),
      .result   (div_result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (err_ff != pse_pkg::ST_OK) begin
            rsp_value_ff  <= '0;
            rsp_status_ff <= err_ff;
         end else if (count_ff == '0) begin
            rsp_value_ff  <= '0;
            rsp_status_ff <= pse_pkg::ST_EMPTY;
         end else begin
            rsp_value_ff  <= rd_data;
            rsp_status_ff <= pse_pkg::ST_OK;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

   // status to the controller
   always_comb begin
      sts.is_load    = opcode_ff;
      sts.has_error  = err_ff != pse_pkg::ST_OK;
      sts.is_letter  = letter_off < 8'(VC);
      sts.is_space   = char_ff == pse_pkg::CH_SPACE;
      sts.stack_full = count_ff >= CW'(pse_pkg::STACK_DEPTH);
      sts.under_two  = count_ff < CW'(2);
      sts.is_div     = char_ff == pse_pkg::CH_DIV || char_ff == pse_pkg::CH_MOD;
      sts.rhs_zero   = rhs_ff == '0;
      sts.div_done   = div_done;
      sts.last       = last_ff;
      sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(pse_pkg::STACK_DEPTH))
      else $error("stack count beyond depth");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> count_ff == '0 && err_ff == pse_pkg::ST_OK && rsp_valid_ff)
      else $error("emit did not clear the stack");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> count_ff < CW'(pse_pkg::STACK_DEPTH))
      else $error("push onto full stack");

endmodule
`default_nettype wire

>>> rtl/pse_ctrl.sv
// sequencing state machine of the evaluator
`default_nettype none
module pse_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire pse_pkg::sts_type sts,
   output pse_pkg::cmd_type      cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_RD_RHS = 4'd2;
   localparam logic [3:0] S_RD_LHS = 4'd3;
   localparam logic [3:0] S_EXEC   = 4'd4;
   localparam logic [3:0] S_DIV    = 4'd5;
   localparam logic [3:0] S_PUSH   = 4'd6;
   localparam logic [3:0] S_FINISH = 4'd7;
   localparam logic [3:0] S_TOP    = 4'd8;

   logic [3:0] state_ff, state_in;

   assign req_stall = state_ff != S_IDLE;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_FINISH;
            priority if (sts.is_load) begin
               cmd.var_write = 1'b1;
            end else if (sts.has_error || sts.is_space) begin
               state_in = S_FINISH;
            end else if (sts.is_letter) begin
               if (sts.stack_full) begin
                  cmd.err_write = 1'b1;
                  cmd.err_code  = pse_pkg::ST_OVERFLOW;
               end else begin
                  cmd.push_var = 1'b1;
               end
            end else if (sts.under_two) begin
               cmd.err_write = 1'b1;
               cmd.err_code  = pse_pkg::ST_UNDERFLOW;
            end else begin
               state_in = S_RD_RHS;
            end
         end
         S_RD_RHS: begin
            cmd.cap_rhs   = 1'b1;
            cmd.rd_second = 1'b1;
            state_in      = S_RD_LHS;
         end
         S_RD_LHS: begin
            cmd.cap_lhs = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            if (sts.is_div) begin
               if (sts.rhs_zero) begin
                  cmd.err_write = 1'b1;
                  cmd.err_code  = pse_pkg::ST_DIVZERO;
                  state_in      = S_FINISH;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
            end else begin
               cmd.alu_exec = 1'b1;
               state_in     = S_PUSH;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = S_PUSH;
            end
         end
         S_PUSH: begin
            cmd.push_result = 1'b1;
            state_in        = S_FINISH;
         end
         S_FINISH: begin
            state_in = sts.last ? S_TOP : S_IDLE;
         end
         S_TOP: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |=> state_ff == S_DECODE)
      else $error("accepted item not decoded");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> state_ff == S_DIV && !sts.div_done)
      else $error("divider finished too early");

   a_emit_last: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.last && state_ff == S_TOP)
      else $error("result emitted for item not marked last");

endmodule
`default_nettype wire

>>> rtl/postfix_stack_evaluator.sv
// top level of the postfix expression stack evaluator
// An expression arrives one item per req_ transfer: with req_opcode low,
// req_token_char is a character (A..Z push a variable, space is skipped,
// + - * / % combine the two top values, any other character combines them
// to zero); with req_opcode high, req_var_value is stored in variable
// req_var_index. The item with req_last_token high gives one rsp_ transfer
// with the stack top and a status, then the stack and error are cleared.
// One item is in work at a time; req_stall stays high until it is done.
// Item steps: a load, letter, space or ignored item is decoded and
// finished; + - * and other operators read both operands from the stack
// memory, execute and push; / and % instead run the shared one-bit-per-
// cycle divider unless the divisor is zero. A last item then reads the
// stack top from the stack memory into the output register.
// The output register holds a result while rsp_stall is high; the next
// items are still taken, and only a following last item waits for it.
// Synchronous reset empties the stack, clears the error and sets all
// variables to zero; no clearing pass is needed.
`default_nettype none
module postfix_stack_evaluator (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_opcode,
   input  wire logic [7:0]         req_token_char,
   input  wire logic [4:0]         req_var_index,
   input  wire logic signed [31:0] req_var_value,
   input  wire logic               req_last_token,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_result_value,
   output logic      [2:0]         rsp_status
);

   pse_pkg::cmd_type cmd;
   pse_pkg::sts_type sts;

   // sequencer
   pse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // stack and arithmetic
   pse_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_opcode),
      .req_token_char   (req_token_char),
      .req_var_index    (req_var_index),
      .req_var_value    (req_var_value),
      .req_last_token   (req_last_token),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

endmodule
`default_nettype wire
